// File: hdl/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// shared types and constants for the ip packet port filter
// ----------------------------------------------------------------------------
package dpf_pkg;

    typedef enum logic [1:0] {
        VERDICT_SKIP = 2'd0,
        VERDICT_BAD  = 2'd1,
        VERDICT_FWD  = 2'd2
    } verdict_t;

    localparam logic [7:0]  PROTO_ICMP  = 8'h01;
    localparam logic [7:0]  PROTO_TCP   = 8'h06;
    localparam logic [7:0]  PROTO_UDP   = 8'h11;
    localparam logic [7:0]  PROTO_ICMP6 = 8'h3A;
    localparam logic [7:0]  PROTO_FRAG6 = 8'h2C;
    localparam logic [15:0] DNS_PORT_RESET = 16'd53;
    localparam logic [15:0] MIN_LEN     = 16'd20;
    localparam logic [5:0]  V6_HDR_LEN  = 6'd40;
    localparam logic [15:0] V6_PORT_END = 16'd44;
    localparam logic [15:0] FRAG_MASK   = 16'h3FFF;
    localparam logic [3:0]  IP_V4       = 4'd4;
    localparam logic [3:0]  IP_V6       = 4'd6;

    // header fields as they stand after the current byte
    typedef struct packed {
        logic [15:0] count;
        logic [3:0]  version;
        logic [3:0]  hwords;
        logic [7:0]  proto;
        logic [7:0]  next_hdr;
        logic [15:0] frag;
        logic [15:0] sport;
        logic [15:0] dport;
    } hdr_t;

endpackage

// File: hdl/dpf_capture.sv
// ----------------------------------------------------------------------------
// dpf_capture
// byte counter and header field capture for one packet
// ----------------------------------------------------------------------------
module dpf_capture
    import dpf_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 65535
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] pkt_byte,
    input  logic       last_byte,
    output hdr_t       hdr_next
);

    localparam logic [15:0] MaxBytes = 16'(MAX_PACKET_BYTES);

    hdr_t        hdr_reg;
    logic [15:0] idx;
    logic [3:0]  ver_eff;
    logic [3:0]  hw_eff;
    logic [5:0]  ofs;
    logic [16:0] diff;

    assign idx = hdr_reg.count;

    always_comb
    begin
        hdr_next = hdr_reg;
        ver_eff  = hdr_reg.version;
        hw_eff   = hdr_reg.hwords;
        ofs      = 6'd0;
        diff     = 17'd0;
        if (idx < MaxBytes)
        begin
            if (idx == 16'd0)
            begin
                ver_eff = pkt_byte[7:4];
                hw_eff  = pkt_byte[3:0];
            end
            hdr_next.version = ver_eff;
            hdr_next.hwords  = hw_eff;
            if (idx == 16'd6)
            begin
                hdr_next.frag[15:8] = pkt_byte;
                hdr_next.next_hdr   = pkt_byte;
            end
            else if (idx == 16'd7)
            begin
                hdr_next.frag[7:0] = pkt_byte;
            end
            else if (idx == 16'd9)
            begin
                hdr_next.proto = pkt_byte;
            end
            ofs  = (ver_eff == IP_V6) ? V6_HDR_LEN : {hw_eff, 2'b00};
            diff = {1'b0, idx} - {11'd0, ofs};
            // port bytes, source first, big-endian
            if (idx >= {10'd0, ofs} && diff < 17'd4)
            begin
                case (diff[1:0])
                    2'd0:    hdr_next.sport[15:8] = pkt_byte;
                    2'd1:    hdr_next.sport[7:0]  = pkt_byte;
                    2'd2:    hdr_next.dport[15:8] = pkt_byte;
                    default: hdr_next.dport[7:0]  = pkt_byte;
                endcase
            end
            hdr_next.count = idx + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
                hdr_reg <= '0;
            else
                hdr_reg <= hdr_next;
        end
    end

endmodule

// File: hdl/dpf_verdict.sv
// ----------------------------------------------------------------------------
// dpf_verdict
// verdict decision from the captured header fields
// ----------------------------------------------------------------------------
module dpf_verdict
    import dpf_pkg::*;
(
    input  hdr_t        hdr,
    input  logic        sink_up,
    input  logic [15:0] dns_port,
    output verdict_t    verdict
);

    logic        port_hit;
    logic [15:0] v4_port_end;
    logic        is_l4_v4;
    logic        is_l4_v6;

    assign port_hit    = (hdr.sport == dns_port) || (hdr.dport == dns_port);
    assign v4_port_end = {10'd0, hdr.hwords, 2'b00} + 16'd4;
    assign is_l4_v4    = (hdr.proto == PROTO_TCP) || (hdr.proto == PROTO_UDP);
    assign is_l4_v6    = (hdr.next_hdr == PROTO_TCP) || (hdr.next_hdr == PROTO_UDP);

    always_comb
    begin
        verdict = VERDICT_BAD;
        if (!sink_up)
            verdict = VERDICT_SKIP;
        else if (hdr.count < MIN_LEN)
            verdict = VERDICT_BAD;
        else if (hdr.version == IP_V4)
        begin
            if (hdr.proto == PROTO_ICMP)
                verdict = VERDICT_FWD;
            else if (is_l4_v4)
            begin
                if (hdr.count < v4_port_end)
                    verdict = VERDICT_BAD;
                else
                    verdict = port_hit ? VERDICT_FWD : VERDICT_SKIP;
            end
            else
                verdict = ((hdr.frag & FRAG_MASK) != 16'd0) ? VERDICT_FWD : VERDICT_SKIP;
        end
        else if (hdr.version == IP_V6)
        begin
            if (hdr.next_hdr == PROTO_ICMP6 || hdr.next_hdr == PROTO_FRAG6)
                verdict = VERDICT_FWD;
            else if (is_l4_v6)
            begin
                if (hdr.count < V6_PORT_END)
                    verdict = VERDICT_BAD;
                else
                    verdict = port_hit ? VERDICT_FWD : VERDICT_SKIP;
            end
            else
                verdict = VERDICT_SKIP;
        end
    end

endmodule

// File: hdl/dns_packet_filter.sv
// ----------------------------------------------------------------------------
// dns_packet_filter
// ip packet port filter giving one verdict per packet
// ----------------------------------------------------------------------------
// The block takes an IP packet one byte per item on the slave stream, with
// tlast on the final byte, and gives one result item per packet on the master
// stream: a verdict (skipped, malformed, forward) and the saturated byte count.
// Header capture and the verdict are a single pass of logic between the
// capture registers and the output register, so a byte is taken in every
// cycle as long as the output register is empty or is being drained in that
// cycle. The verdict item appears the cycle after the last byte is accepted.
// ICMP, ICMPv6, IPv4 fragments that are not TCP/UDP, IPv6 fragment headers
// and TCP/UDP packets with either port equal to dns_port are forwarded; the
// port register resets to 53 and should be written only while no packet is
// in flight. tuser on the last byte tells whether the sink is up; when it is
// low the verdict is skipped.
// ----------------------------------------------------------------------------
module dns_packet_filter
    import dpf_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pkt_byte
    input  logic        s_tlast,    // last_byte
    input  logic        s_tuser,    // sink_up
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [1:0] verdict, [17:2] packet_length, rest zero
    // dns port register
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic        accept;
    logic        emit;
    hdr_t        hdr_next;
    verdict_t    verdict;

    logic [15:0] dns_port_reg;
    logic        m_valid_reg;
    verdict_t    verdict_reg;
    logic [15:0] length_reg;

    // output register frees up when empty or drained this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign emit     = accept && s_tlast;

    dpf_capture #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pkt_byte  (s_tdata),
        .last_byte (s_tlast),
        .hdr_next  (hdr_next)
    );

    dpf_verdict u_verdict (
        .hdr      (hdr_next),
        .sink_up  (s_tuser),
        .dns_port (dns_port_reg),
        .verdict  (verdict)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dns_port_reg <= DNS_PORT_RESET;
        else if (cfg_we)
            dns_port_reg <= cfg_wdata;
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (emit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            verdict_reg <= verdict;
            length_reg  <= hdr_next.count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, length_reg, verdict_reg};

endmodule

// File: hdl/dpf_checker.sv
// ----------------------------------------------------------------------------
// dpf_checker
// port-level assertions for the ip packet port filter
// ----------------------------------------------------------------------------
module dpf_checker
    import dpf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // empty output register never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a result appears only after an accepted last byte
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without last byte");

    // sink down gives a skipped verdict
    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && !s_tuser |=>
            m_tvalid && m_tdata[1:0] == VERDICT_SKIP)
        else $error("sink down not skipped");

    // verdict code is never the unused value
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad verdict code");

endmodule

bind dns_packet_filter dpf_checker u_dpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
